### src/vcso_pkg.sv
package vcso_pkg;

	localparam int MAX_ROW_LENGTH = 1024;
	localparam int ROW_INDEX_BITS = 12;
	localparam int COL_BITS = $clog2(MAX_ROW_LENGTH);
	localparam int LEN_BITS = 11;
	localparam int WIDE = 68;

	localparam logic [2:0] REG_ROW_LENGTH = 3'd0;
	localparam logic [2:0] REG_X_ORIGIN = 3'd1;
	localparam logic [2:0] REG_X_STEP = 3'd2;
	localparam logic [2:0] REG_Y_ORIGIN = 3'd3;
	localparam logic [2:0] REG_Y_STEP = 3'd4;
	localparam logic [2:0] REG_X_COEFF = 3'd5;
	localparam logic [2:0] REG_Y_COEFF = 3'd6;
	localparam logic [2:0] REG_RESIDUAL = 3'd7;

	typedef logic signed [31:0] val_t;
	typedef logic signed [WIDE-1:0] wide_t;
	typedef logic signed [32:0] mop_t;
	typedef logic signed [65:0] prod_t;

	typedef struct packed {
		val_t up;
		val_t mid;
		val_t rhs;
	} line_word_t;

	localparam val_t VMAX = 32'sh7FFFFFFF;
	localparam val_t VMIN = 32'sh80000000;

	function automatic val_t sat_v(input wide_t v);
		if (v > wide_t'(VMAX)) begin
			return VMAX;
		end else if (v < wide_t'(VMIN)) begin
			return VMIN;
		end
		return v[31:0];
	endfunction

	function automatic logic sat_f(input wide_t v);
		return (v > wide_t'(VMAX)) || (v < wide_t'(VMIN));
	endfunction

endpackage

### src/vcso_lines.sv
module vcso_lines
	import vcso_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [COL_BITS-1:0] rd_addr,
	input  logic                wr_en,
	input  logic [COL_BITS-1:0] wr_addr,
	input  line_word_t          wr_data,
	output line_word_t          rd_data
);

	val_t up_mem [MAX_ROW_LENGTH];
	val_t mid_mem [MAX_ROW_LENGTH];
	val_t rhs_mem [MAX_ROW_LENGTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			up_mem[wr_addr] <= wr_data.up;
			mid_mem[wr_addr] <= wr_data.mid;
			rhs_mem[wr_addr] <= wr_data.rhs;
		end
		if (rd_en) begin
			rd_data.up <= up_mem[rd_addr];
			rd_data.mid <= mid_mem[rd_addr];
			rd_data.rhs <= rhs_mem[rd_addr];
		end
	end

endmodule

### src/variable_coeff_stencil_operator.sv
// A word that yields a result is read and then worked through the sequencer steps;
// a word that yields no result (boundary node) only passes through the read state.
// The block takes no new word until it is back in idle; interior words use the single
// shared 33 by 33 bit multiplier stepped through sixteen sequencer steps.
// Reset sets the settings to defaults and clears the counters, window and output
// valid flag; the line stores are not cleared and hold unknown data until written.
module variable_coeff_stencil_operator
	import vcso_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [47:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [31:0]        node_value,
	input  logic signed [31:0]        rhs_value,
	input  logic                      first_node,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        operator_value,
	output logic [ROW_INDEX_BITS-1:0] centre_row,
	output logic [COL_BITS-1:0]       centre_col,
	output logic                      saturated
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CALC = 2'd2;
	localparam logic [4:0] LAST = 5'd16;

	logic [LEN_BITS-1:0] row_length_q;
	val_t x_origin_q, y_origin_q;
	logic [30:0] x_step_q, y_step_q;
	logic [47:0] x_coeff_q, y_coeff_q;
	logic residual_q;

	logic [1:0] state_q;
	logic [4:0] step_q;
	logic [ROW_INDEX_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	val_t win0_q, win1_q, win2_q, win3_q, win4_q;
	logic out_valid_q;

	logic produce_q;
	logic [COL_BITS-1:0] waddr_q;
	logic [ROW_INDEX_BITS-1:0] rr_q;
	logic [COL_BITS-1:0] cc_q;
	val_t gin_q, fin_q;
	val_t g_q, fr_q, dd_q, du_q, dr_q, dl_q, d2_q;
	val_t x_q, y_q, kp_q, km_q, k0_q, s_q, a_q, q_q, tx_q, ty_q, qg_q;
	val_t lx_q, ly_q, lap_q, res_q;
	prod_t prod_q, hi_q;
	logic flag_q;

	val_t out_value_q;
	logic [ROW_INDEX_BITS-1:0] out_row_q;
	logic [COL_BITS-1:0] out_col_q;
	logic out_sat_q;

	logic accept, out_free, out_load;
	logic [ROW_INDEX_BITS-1:0] cur_row;
	logic [COL_BITS-1:0] cur_col;
	logic [LEN_BITS-1:0] len;
	line_word_t rd_line, wr_line;
	mop_t mul_a, mul_b;
	wide_t dd_w, du_w, dr_w, dl_w;
	wide_t mulc_w;
	logic mulc_ovf;
	logic [49:0] mulc_p;
	wide_t step_w;
	val_t step_v;
	logic step_f;
	logic k_f;
	val_t fin_v;
	logic fin_f;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_CALC) && (step_q == LAST) && out_free;

	assign cur_row = first_node ? '0 : row_q;
	assign cur_col = first_node ? '0 : col_q;

	always_comb begin
		if (row_length_q < LEN_BITS'(3)) begin
			len = LEN_BITS'(3);
		end else if (row_length_q > LEN_BITS'(MAX_ROW_LENGTH)) begin
			len = LEN_BITS'(MAX_ROW_LENGTH);
		end else begin
			len = row_length_q;
		end
	end

	assign wr_line.up = rd_line.mid;
	assign wr_line.mid = gin_q;
	assign wr_line.rhs = fin_q;

	vcso_lines u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (cur_col),
		.wr_en   (state_q == S_READ),
		.wr_addr (waddr_q),
		.wr_data (wr_line),
		.rd_data (rd_line)
	);

	assign dd_w = wide_t'(win3_q) - wide_t'(win2_q);
	assign du_w = wide_t'(win2_q) - wide_t'(win0_q);
	assign dr_w = wide_t'(rd_line.mid) - wide_t'(win2_q);
	assign dl_w = wide_t'(win2_q) - wide_t'(win1_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			5'd1: begin
				mul_a = mop_t'($signed({1'b0, rr_q}));
				mul_b = mop_t'($signed({1'b0, x_step_q}));
			end
			5'd2: begin
				mul_a = mop_t'($signed({1'b0, cc_q}));
				mul_b = mop_t'($signed({1'b0, y_step_q}));
			end
			5'd4: begin
				mul_a = mop_t'(kp_q);
				mul_b = mop_t'(dd_q);
			end
			5'd5: begin
				mul_a = mop_t'(s_q);
				mul_b = mop_t'(s_q);
			end
			5'd6: begin
				mul_a = mop_t'(km_q);
				mul_b = mop_t'(du_q);
			end
			5'd7: begin
				mul_a = mop_t'(k0_q);
				mul_b = mop_t'(d2_q);
			end
			5'd8: begin
				mul_a = mop_t'(q_q);
				mul_b = mop_t'(g_q);
			end
			5'd9, 5'd10: begin
				mul_a = tx_q[31] ? -mop_t'(tx_q) : mop_t'(tx_q);
				mul_b = (step_q == 5'd9) ? mop_t'($signed({1'b0, x_coeff_q[47:16]}))
					: mop_t'($signed({17'b0, x_coeff_q[15:0]}));
			end
			5'd11, 5'd12: begin
				mul_a = ty_q[31] ? -mop_t'(ty_q) : mop_t'(ty_q);
				mul_b = (step_q == 5'd11) ? mop_t'($signed({1'b0, y_coeff_q[47:16]}))
					: mop_t'($signed({17'b0, y_coeff_q[15:0]}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The coefficient product is rebuilt from its high and low partial products.
	always_comb begin
		logic neg;
		wide_t pw;
		neg = (step_q == 5'd11) ? tx_q[31] : ty_q[31];
		mulc_ovf = |hi_q[65:32];
		mulc_p = {2'b0, hi_q[31:0], 16'b0} + 50'(prod_q[47:0]);
		pw = wide_t'($signed({1'b0, mulc_p}));
		if (mulc_ovf) begin
			mulc_w = neg ? wide_t'(VMIN) : wide_t'(VMAX);
		end else begin
			mulc_w = (neg ? -pw : pw) >>> 16;
		end
	end

	always_comb begin
		unique case (step_q)
			5'd1: step_w = wide_t'(dr_q) - wide_t'(dl_q);
			5'd2: step_w = wide_t'(x_origin_q) + wide_t'(prod_q);
			5'd3: step_w = wide_t'(y_origin_q) + wide_t'(prod_q);
			5'd4: step_w = wide_t'(x_q) + wide_t'(y_q);
			5'd7: step_w = wide_t'(a_q) - wide_t'(sat_v(wide_t'(prod_q >>> 16)));
			5'd11, 5'd13: step_w = mulc_w;
			5'd14: step_w = wide_t'(lx_q) + wide_t'(ly_q);
			5'd15: step_w = wide_t'(qg_q) - wide_t'(lap_q);
			default: step_w = wide_t'(prod_q >>> 16);
		endcase
	end

	assign step_v = sat_v(step_w);
	assign fin_v = sat_v(wide_t'(res_q) - wide_t'(fr_q));
	assign fin_f = residual_q && sat_f(wide_t'(res_q) - wide_t'(fr_q));

	assign k_f = (step_q == 5'd3) && (
		sat_f(wide_t'(x_q) + wide_t'(32'sh40000) + wide_t'({x_step_q[30:1]}))
		|| sat_f(wide_t'(x_q) + wide_t'(32'sh40000) - wide_t'({x_step_q[30:1]}))
		|| sat_f(wide_t'(x_q) + wide_t'(32'sh40000)));

	always_comb begin
		unique case (step_q)
			5'd7: step_f = sat_f(step_w) || sat_f(wide_t'(prod_q >>> 16));
			5'd11, 5'd13: step_f = mulc_ovf || sat_f(step_w);
			5'd10, 5'd12, 5'd16: step_f = 1'b0;
			default: step_f = sat_f(step_w);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= LEN_BITS'(MAX_ROW_LENGTH);
			x_origin_q <= '0;
			x_step_q <= 31'h10000;
			y_origin_q <= '0;
			y_step_q <= 31'h10000;
			x_coeff_q <= 48'h10000;
			y_coeff_q <= 48'h10000;
			residual_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data[LEN_BITS-1:0];
				REG_X_ORIGIN: x_origin_q <= cfg_data[31:0];
				REG_X_STEP: x_step_q <= cfg_data[30:0];
				REG_Y_ORIGIN: y_origin_q <= cfg_data[31:0];
				REG_Y_STEP: y_step_q <= cfg_data[30:0];
				REG_X_COEFF: x_coeff_q <= cfg_data;
				REG_Y_COEFF: y_coeff_q <= cfg_data;
				REG_RESIDUAL: residual_q <= cfg_data[0];
				default: residual_q <= residual_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			row_q <= '0;
			col_q <= '0;
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
			win3_q <= '0;
			win4_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
						if ({1'b0, cur_col} + LEN_BITS'(1) >= len) begin
							col_q <= '0;
							row_q <= cur_row + ROW_INDEX_BITS'(1);
						end else begin
							col_q <= cur_col + COL_BITS'(1);
							row_q <= cur_row;
						end
					end
				end
				S_READ: begin
					win1_q <= win2_q;
					win2_q <= rd_line.mid;
					win0_q <= rd_line.up;
					win3_q <= gin_q;
					win4_q <= rd_line.rhs;
					step_q <= 5'd1;
					state_q <= produce_q ? S_CALC : S_IDLE;
				end
				S_CALC: begin
					if (step_q != LAST) begin
						step_q <= step_q + 5'd1;
					end else if (out_free) begin
						step_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			produce_q <= (cur_row >= ROW_INDEX_BITS'(2)) && (cur_col >= COL_BITS'(2));
			rr_q <= cur_row - ROW_INDEX_BITS'(1);
			cc_q <= cur_col - COL_BITS'(1);
			waddr_q <= cur_col;
			gin_q <= node_value;
			fin_q <= rhs_value;
		end
		if (state_q == S_READ) begin
			g_q <= win2_q;
			fr_q <= win4_q;
			dd_q <= sat_v(dd_w);
			du_q <= sat_v(du_w);
			dr_q <= sat_v(dr_w);
			dl_q <= sat_v(dl_w);
			flag_q <= sat_f(dd_w) || sat_f(du_w) || sat_f(dr_w) || sat_f(dl_w);
		end
		if (state_q == S_CALC) begin
			prod_q <= mul_a * mul_b;
			flag_q <= flag_q || step_f || k_f;
			unique case (step_q)
				5'd1: d2_q <= step_v;
				5'd2: x_q <= step_v;
				5'd3: begin
					y_q <= step_v;
					kp_q <= sat_v(wide_t'(x_q) + wide_t'(32'sh40000)
						+ wide_t'({x_step_q[30:1]}));
					km_q <= sat_v(wide_t'(x_q) + wide_t'(32'sh40000)
						- wide_t'({x_step_q[30:1]}));
					k0_q <= sat_v(wide_t'(x_q) + wide_t'(32'sh40000));
				end
				5'd4: s_q <= step_v;
				5'd5: a_q <= step_v;
				5'd6: q_q <= step_v;
				5'd7: tx_q <= step_v;
				5'd8: ty_q <= step_v;
				5'd9: qg_q <= step_v;
				5'd10, 5'd12: hi_q <= prod_q;
				5'd11: lx_q <= step_v;
				5'd13: ly_q <= step_v;
				5'd14: lap_q <= step_v;
				5'd15: res_q <= step_v;
				default: begin
					if (out_free) begin
						out_value_q <= residual_q ? fin_v : res_q;
						out_sat_q <= flag_q || fin_f;
						out_row_q <= rr_q;
						out_col_q <= cc_q;
					end
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign operator_value = out_value_q;
	assign centre_row = out_row_q;
	assign centre_col = out_col_q;
	assign saturated = out_sat_q;

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_READ))
		else $error("accepted word did not start a line read");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) |-> (step_q >= 5'd1 && step_q <= LAST))
		else $error("sequencer step out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(operator_value))
		else $error("waiting result overwritten");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (centre_col != '0))
		else $error("result issued for a boundary column");

endmodule

### verif/tb_variable_coeff_stencil_operator.sv
module tb_variable_coeff_stencil_operator;
	import vcso_pkg::*;

	typedef struct {
		int          value;
		logic [11:0] row;
		logic [9:0]  col;
		bit          clip;
	} stencil_result_t;

	class stencil_scoreboard;
		int unsigned      row_len;
		longint           x_org, x_stp, y_org, y_stp;
		longint unsigned  x_cf, y_cf;
		bit               residual;
		longint           upper_mem[MAX_ROW_LENGTH];
		longint           middle_mem[MAX_ROW_LENGTH];
		longint           rhs_mem[MAX_ROW_LENGTH];
		longint           win[6];
		int unsigned      row_cnt, col_cnt;
		bit               clip;
		stencil_result_t  pending[$];
		int               errors;
		int               checked;

		function new();
			row_len = 1024;
			x_org = 0;
			x_stp = 65536;
			y_org = 0;
			y_stp = 65536;
			x_cf = 65536;
			y_cf = 65536;
			residual = 0;
			foreach (win[i]) win[i] = 0;
			row_cnt = 0;
			col_cnt = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void configure(logic [2:0] idx, logic [47:0] data);
			case (idx)
				REG_ROW_LENGTH: row_len = data[10:0];
				REG_X_ORIGIN:   x_org = longint'($signed(data[31:0]));
				REG_X_STEP:     x_stp = longint'(data[30:0]);
				REG_Y_ORIGIN:   y_org = longint'($signed(data[31:0]));
				REG_Y_STEP:     y_stp = longint'(data[30:0]);
				REG_X_COEFF:    x_cf = data;
				REG_Y_COEFF:    y_cf = data;
				REG_RESIDUAL:   residual = data[0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > 64'sd2147483647) begin
				clip = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clip = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function longint fmul(longint a, longint b);
			return clamp((a * b) >>> 16);
		endfunction

		function longint cmul(longint unsigned cf, longint t);
			longint unsigned m;
			longint unsigned p;
			longint sp;
			m = (t < 0) ? longint'(-t) : t;
			if (m * (cf >> 16) >= 64'd4294967296) begin
				clip = 1;
				return (t < 0) ? -64'sd2147483648 : 64'sd2147483647;
			end
			p = m * cf;
			sp = (t < 0) ? -longint'(p) : longint'(p);
			return clamp(sp >>> 16);
		endfunction

		function void note_node(int g_word, int f_word, bit first);
			longint g_in, f_in, up_c, mid_c, rhs_c;
			longint rr, cc, x, y, half, kp, km, k0, s, q, dd, du, dr, dl, d2;
			longint tx, ty, lap, res;
			int unsigned len, c;
			stencil_result_t r;
			g_in = g_word;
			f_in = f_word;
			if (first) begin
				row_cnt = 0;
				col_cnt = 0;
			end
			len = row_len;
			if (len < 3) len = 3;
			if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
			c = col_cnt % MAX_ROW_LENGTH;
			up_c = upper_mem[c];
			mid_c = middle_mem[c];
			rhs_c = rhs_mem[c];
			if (row_cnt >= 2 && c >= 2) begin
				clip = 0;
				rr = row_cnt - 1;
				cc = c - 1;
				x = clamp(x_org + rr * x_stp);
				y = clamp(y_org + cc * y_stp);
				half = x_stp >>> 1;
				kp = clamp(262144 + x + half);
				km = clamp(262144 + x - half);
				k0 = clamp(262144 + x);
				s = clamp(x + y);
				q = fmul(s, s);
				dd = clamp(win[3] - win[2]);
				du = clamp(win[2] - win[0]);
				dr = clamp(mid_c - win[2]);
				dl = clamp(win[2] - win[1]);
				d2 = clamp(dr - dl);
				tx = clamp(fmul(kp, dd) - fmul(km, du));
				ty = fmul(k0, d2);
				lap = clamp(cmul(x_cf, tx) + cmul(y_cf, ty));
				res = clamp(-lap + fmul(q, win[2]));
				if (residual) res = clamp(res - win[4]);
				r.value = int'(res);
				r.row = rr[11:0];
				r.col = cc[9:0];
				r.clip = clip;
				pending.push_back(r);
			end
			win[1] = win[2];
			win[2] = mid_c;
			win[0] = up_c;
			win[3] = g_in;
			win[4] = rhs_c;
			win[5] = mid_c;
			upper_mem[c] = mid_c;
			middle_mem[c] = g_in;
			rhs_mem[c] = f_in;
			if (col_cnt + 1 >= len) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1) & 12'hFFF;
			end else begin
				col_cnt++;
			end
		endfunction

		function void check_result(int value, logic [11:0] row, logic [9:0] col, bit clp);
			stencil_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: value %h row %0d col %0d", value, row, col);
				return;
			end
			e = pending.pop_front();
			if (e.value !== value || e.row !== row || e.col !== col || e.clip !== clp) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h r%0d c%0d s%0b, got %h r%0d c%0d s%0b",
						e.value, e.row, e.col, e.clip, value, row, col, clp);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [2:0]         cfg_index = REG_ROW_LENGTH;
	logic [47:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] node_value = '0;
	logic signed [31:0] rhs_value = '0;
	logic               first_node = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] operator_value;
	logic [11:0]        centre_row;
	logic [9:0]         centre_col;
	logic               saturated;

	stencil_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int random_nodes = 0;
	int grids = 0;

	variable_coeff_stencil_operator dut (.*);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_node(node_value, rhs_value, first_node);
			if (out_valid && !out_stall)
				sb.check_result(operator_value, centre_row, centre_col, saturated);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] data);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		sb.configure(idx, data);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic send_node(int g, int f, bit first);
		while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
		in_valid = 1;
		node_value = g;
		rhs_value = f;
		first_node = first;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic int pick_word();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
		endcase
	endfunction

	task automatic run_grid(int rows, int cols, bit mark, int pause_at);
		for (int i = 0; i < rows * cols; i++) begin
			if (i == pause_at) wait_drained();
			send_node(pick_word(), pick_word(), mark && i == 0);
		end
		grids++;
	endtask

	task automatic random_settings(int len);
		write_reg(REG_ROW_LENGTH, 48'(len));
		write_reg(REG_X_ORIGIN, 48'($urandom_range(3) == 0 ? $urandom :
			int'($urandom_range(0, 1 << 19)) - (1 << 18)));
		write_reg(REG_Y_ORIGIN, 48'($urandom_range(3) == 0 ? $urandom :
			int'($urandom_range(0, 1 << 19)) - (1 << 18)));
		write_reg(REG_X_STEP, 48'($urandom_range(3) == 0 ? $urandom >> 1 :
			$urandom_range(1 << 10, 1 << 17)));
		write_reg(REG_Y_STEP, 48'($urandom_range(3) == 0 ? $urandom >> 1 :
			$urandom_range(1 << 10, 1 << 17)));
		write_reg(REG_X_COEFF, $urandom_range(3) == 0 ? 48'({$urandom, $urandom}) :
			48'($urandom_range(0, 1 << 22)));
		write_reg(REG_Y_COEFF, $urandom_range(3) == 0 ? 48'({$urandom, $urandom}) :
			48'($urandom_range(0, 1 << 22)));
		write_reg(REG_RESIDUAL, 48'($urandom_range(1)));
	endtask

	initial begin
		#8000000;
		$display("variable_coeff_stencil_operator test failed");
		$finish;
	end

	initial begin
		int len;
		int rows;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: smallest clamped row, extreme words and settings.
		write_reg(REG_ROW_LENGTH, 0);
		write_reg(REG_RESIDUAL, 1);
		for (int i = 0; i < 12; i++)
			send_node(i % 3 == 0 ? 32'h7FFFFFFF : (i % 3 == 1 ? 32'h80000000 : 0),
				i % 2 ? 32'h80000000 : 32'h7FFFFFFF, i == 0);
		wait_drained();
		write_reg(REG_X_ORIGIN, 48'h7FFFFFFF);
		write_reg(REG_Y_ORIGIN, 48'h80000000);
		write_reg(REG_X_STEP, 48'h7FFFFFFF);
		write_reg(REG_Y_STEP, 0);
		write_reg(REG_X_COEFF, 48'hFFFFFFFFFFFF);
		write_reg(REG_Y_COEFF, 0);
		write_reg(REG_ROW_LENGTH, 2);
		run_grid(4, 3, 1, -1);
		wait_drained();

		// Row length lowered part way through a grid.
		random_settings(8);
		run_grid(3, 8, 1, -1);
		for (int i = 0; i < 7; i++) send_node(pick_word(), pick_word(), 0);
		wait_drained();
		write_reg(REG_ROW_LENGTH, 4);
		run_grid(5, 4, 0, 9);
		wait_drained();

		while (random_nodes < 425) begin
			case (grids % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 64; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 64; end
				default: begin send_idle = 31; recv_stall = 31; end
			endcase
			len = $urandom_range(6) == 0 ? $urandom_range(13, 40) : $urandom_range(3, 10);
			random_settings(len);
			rows = $urandom_range(3, 8);
			run_grid(rows, len, 1, -1);
			random_nodes += rows * len;
			wait_drained();
		end

		send_idle = 0;
		recv_stall = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("%0d grids, %0d results checked over four idling patterns,", grids, sb.checked);
		$display("including row length clamping below the minimum and mid-grid shortening.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("variable_coeff_stencil_operator test passed");
		end else begin
			$display("variable_coeff_stencil_operator test failed");
		end
		$finish;
	end

endmodule
